FILE: sv/lpn2sc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpn2sc_pkg
// Shared types and constants of the length-prefixed to start-code converter.
// ----------------------------------------------------------------------------
package lpn2sc_pkg;

   // Register defaults and limits
   localparam logic [2:0]  LFB_RESET        = 3'd4;
   localparam logic [2:0]  LFB_MIN          = 3'd1;
   localparam logic [2:0]  LFB_MAX          = 3'd4;
   localparam logic [23:0] MAX_PACKET_BYTES = 24'd1048575;
   localparam logic [19:0] OFFSET_MAX       = 20'hFFFFF;
   localparam int          CMD_QUEUE_DEPTH  = 4;

   // Start code bytes
   localparam logic [7:0] START_CODE_ZERO = 8'h00;
   localparam logic [7:0] START_CODE_LAST = 8'h01;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [19:0] packet_bytes;
      logic        last_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       packet_last;
   } rsp_item_type;

   typedef enum logic [1:0] {
      PH_DETECT,
      PH_PASS,
      PH_PARSE,
      PH_DROP
   } phase_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_DATA,
      CMD_START
   } cmd_kind_type;

   // One command from front to back: zero, one or four result bytes
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   value;
      logic         end_run;
      logic         end_pkt;
   } cmd_type;

endpackage

FILE: sv/lpn2sc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpn2sc_front
// Accepts packet bytes, holds the packet head, decides pass-through or
// parse, walks the length fields and pushes data and start-code commands.
// ----------------------------------------------------------------------------
module lpn2sc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lpn2sc_pkg::req_item_type  req_data,
   input  logic [2:0]                cfg_lfb,
   input  logic                      q_full,
   output logic                      cmd_push,
   output lpn2sc_pkg::cmd_type       cmd_data
);
   import lpn2sc_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  head_ff [4];
   logic [19:0] offset_ff, offset_in;
   logic [31:0] accum_ff, accum_in;
   logic [2:0]  seen_ff, seen_in;
   logic [19:0] left_ff, left_in;

   // Head replay control
   logic        rep_active_ff, rep_active_in;
   logic [1:0]  rep_idx_ff, rep_idx_in;
   logic [1:0]  rep_end_ff, rep_end_in;
   logic        rep_last_ff, rep_last_in;
   logic [19:0] rep_size_ff, rep_size_in;

   logic        accept;
   logic        rep_go;
   logic [19:0] size_c;
   logic [19:0] offset_inc;

   // Parse unit
   logic [7:0]   p_byte;
   logic [19:0]  p_pos;
   logic [19:0]  p_size;
   logic [31:0]  acc_sh;
   logic [3:0]   seen_inc;
   logic [20:0]  field_end;
   logic [32:0]  unit_end;
   cmd_kind_type p_kind;
   logic         p_drop;
   logic [31:0]  p_accum;
   logic [2:0]   p_seen;
   logic [19:0]  p_left;

   // Head detection
   logic [1:0]  pos_d;
   logic [2:0]  hold;
   logic [2:0]  h_cnt;
   logic [7:0]  hb [4];
   logic        decide;
   logic        sc3, sc4, badcfg, to_pass;

   assign req_stall = rep_active_ff | q_full;
   assign accept    = req_valid & ~req_stall;
   assign rep_go    = rep_active_ff & ~q_full;

   assign size_c = ({4'b0, req_data.packet_bytes} > MAX_PACKET_BYTES) ?
                   MAX_PACKET_BYTES[19:0] : req_data.packet_bytes;
   assign offset_inc = (offset_ff != OFFSET_MAX) ? offset_ff + 20'd1 : offset_ff;

   // ---------------- parse unit: one byte of the length/payload walk -------
   always_comb begin
      p_byte   = rep_active_ff ? head_ff[rep_idx_ff] : req_data.data_byte;
      p_pos    = rep_active_ff ? {18'b0, rep_idx_ff} : offset_ff;
      p_size   = rep_active_ff ? rep_size_ff : size_c;
      acc_sh   = {accum_ff[23:0], p_byte};
      seen_inc = {1'b0, seen_ff} + 4'd1;
      field_end = {1'b0, p_pos} + {18'b0, cfg_lfb};
      unit_end = {13'b0, p_pos} + 33'd1 + {1'b0, acc_sh};
      p_kind   = CMD_NONE;
      p_drop   = 1'b0;
      p_accum  = accum_ff;
      p_seen   = seen_ff;
      p_left   = left_ff;
      case (phase_ff)
         PH_PASS: begin
            p_kind = CMD_DATA;
         end
         PH_PARSE: begin
            if (left_ff != 20'd0) begin
               p_kind = CMD_DATA;
               p_left = left_ff - 20'd1;
            end else if (seen_ff == 3'd0 && field_end > {1'b0, p_size}) begin
               // length field would run past the packet end
               p_drop = 1'b1;
            end else if (seen_inc < {1'b0, cfg_lfb}) begin
               p_accum = acc_sh;
               p_seen  = seen_inc[2:0];
            end else begin
               p_accum = 32'd0;
               p_seen  = 3'd0;
               if (acc_sh == 32'd0) begin
                  p_kind = CMD_NONE;
               end else if (unit_end > {13'b0, p_size}) begin
                  p_drop = 1'b1;
               end else begin
                  p_kind = CMD_START;
                  p_left = acc_sh[19:0];
               end
            end
         end
         default: begin
            p_kind = CMD_NONE;
         end
      endcase
   end

   // ---------------- head detection ----------------------------------------
   always_comb begin
      pos_d  = offset_ff[1:0];
      hold   = (size_c < 20'd4) ? size_c[2:0] : 3'd4;
      h_cnt  = {1'b0, pos_d} + 3'd1;
      decide = (h_cnt >= hold) || req_data.last_byte;
      for (int i = 0; i < 4; i++) begin
         hb[i] = (pos_d == 2'(i)) ? req_data.data_byte : head_ff[i];
      end
      sc4 = (size_c >= 20'd4) && (pos_d == 2'd3) &&
            (hb[0] == START_CODE_ZERO) && (hb[1] == START_CODE_ZERO) &&
            (hb[2] == START_CODE_ZERO) && (hb[3] == START_CODE_LAST);
      sc3 = (size_c >= 20'd3) && (h_cnt >= 3'd3) &&
            (hb[0] == START_CODE_ZERO) && (hb[1] == START_CODE_ZERO) &&
            (hb[2] == START_CODE_LAST);
      badcfg  = (cfg_lfb < LFB_MIN) || (cfg_lfb > LFB_MAX);
      to_pass = sc4 | sc3 | badcfg;
   end

   // ---------------- next state --------------------------------------------
   always_comb begin
      phase_in      = phase_ff;
      offset_in     = offset_ff;
      accum_in      = accum_ff;
      seen_in       = seen_ff;
      left_in       = left_ff;
      rep_active_in = rep_active_ff;
      rep_idx_in    = rep_idx_ff;
      rep_end_in    = rep_end_ff;
      rep_last_in   = rep_last_ff;
      rep_size_in   = rep_size_ff;
      if (rep_go) begin
         accum_in   = p_accum;
         seen_in    = p_seen;
         left_in    = p_left;
         if (p_drop) begin
            phase_in = PH_DROP;
         end
         rep_idx_in = rep_idx_ff + 2'd1;
         if (rep_idx_ff == rep_end_ff) begin
            rep_active_in = 1'b0;
            if (rep_last_ff) begin
               phase_in = PH_DETECT;
               accum_in = 32'd0;
               seen_in  = 3'd0;
               left_in  = 20'd0;
            end
         end
      end else if (accept) begin
         offset_in = req_data.last_byte ? 20'd0 : offset_inc;
         if (phase_ff == PH_DETECT) begin
            if (decide) begin
               phase_in      = to_pass ? PH_PASS : PH_PARSE;
               accum_in      = 32'd0;
               seen_in       = 3'd0;
               left_in       = 20'd0;
               rep_active_in = 1'b1;
               rep_idx_in    = 2'd0;
               rep_end_in    = pos_d;
               rep_last_in   = req_data.last_byte;
               rep_size_in   = size_c;
            end
         end else begin
            accum_in = p_accum;
            seen_in  = p_seen;
            left_in  = p_left;
            if (p_drop) begin
               phase_in = PH_DROP;
            end
            if (req_data.last_byte) begin
               phase_in = PH_DETECT;
               accum_in = 32'd0;
               seen_in  = 3'd0;
               left_in  = 20'd0;
            end
         end
      end
   end

   // ---------------- outputs -----------------------------------------------
   always_comb begin
      cmd_data.kind    = p_kind;
      cmd_data.value   = p_byte;
      cmd_data.end_run = 1'b0;
      cmd_data.end_pkt = 1'b0;
      cmd_push         = 1'b0;
      if (rep_go) begin
         cmd_data.end_run = (rep_idx_ff == rep_end_ff);
         cmd_data.end_pkt = (rep_idx_ff == rep_end_ff) & rep_last_ff;
         cmd_push         = (p_kind != CMD_NONE) || (rep_idx_ff == rep_end_ff);
      end else if (accept && phase_ff != PH_DETECT) begin
         cmd_data.end_run = 1'b1;
         cmd_data.end_pkt = req_data.last_byte;
         cmd_push         = (p_kind != CMD_NONE) || req_data.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DETECT;
         offset_ff     <= 20'd0;
         accum_ff      <= 32'd0;
         seen_ff       <= 3'd0;
         left_ff       <= 20'd0;
         rep_active_ff <= 1'b0;
         rep_idx_ff    <= 2'd0;
      end else begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         accum_ff      <= accum_in;
         seen_ff       <= seen_in;
         left_ff       <= left_in;
         rep_active_ff <= rep_active_in;
         rep_idx_ff    <= rep_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rep_end_ff  <= rep_end_in;
      rep_last_ff <= rep_last_in;
      rep_size_ff <= rep_size_in;
      if (accept && phase_ff == PH_DETECT) begin
         head_ff[pos_d] <= req_data.data_byte;
      end
   end

endmodule

FILE: sv/lpn2sc_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpn2sc_cmdq
// Small command FIFO between the parsing front and the output back.
// ----------------------------------------------------------------------------
module lpn2sc_cmdq #(
   parameter int DEPTH = lpn2sc_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lpn2sc_pkg::cmd_type  push_data,
   input  logic                 pop,
   output lpn2sc_pkg::cmd_type  head_data,
   output logic                 full,
   output logic                 empty
);
   import lpn2sc_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/lpn2sc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpn2sc_back
// Expands commands into result beats, places run and packet end flags and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module lpn2sc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lpn2sc_pkg::cmd_type       head_data,
   input  logic                      q_empty,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lpn2sc_pkg::rsp_item_type  rsp_data
);
   import lpn2sc_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff;
   logic [1:0]   cnt_ff, cnt_in;
   // last result of a command whose run end is not known yet
   logic         pend_valid_ff, pend_valid_in;
   logic [7:0]   pend_byte_ff;

   logic         out_free;
   logic         fire;
   logic         emit_need;
   rsp_item_type emit_item;
   logic         pop_i;
   logic         pend_set;
   logic         pend_clr;
   logic         res_last;
   logic [7:0]   res_byte;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      emit_need = 1'b0;
      emit_item = '0;
      pop_i     = 1'b0;
      pend_set  = 1'b0;
      pend_clr  = 1'b0;
      cnt_in    = cnt_ff;
      res_last  = (head_data.kind == CMD_DATA) || (cnt_ff == 2'd3);
      if (head_data.kind == CMD_DATA) begin
         res_byte = head_data.value;
      end else begin
         res_byte = (cnt_ff == 2'd3) ? START_CODE_LAST : START_CODE_ZERO;
      end
      if (!q_empty) begin
         case (head_data.kind)
            CMD_DATA, CMD_START: begin
               if (pend_valid_ff) begin
                  emit_need            = 1'b1;
                  emit_item.out_byte   = pend_byte_ff;
                  emit_item.byte_valid = 1'b1;
                  pend_clr             = 1'b1;
               end else if (!res_last) begin
                  emit_need            = 1'b1;
                  emit_item.out_byte   = res_byte;
                  emit_item.byte_valid = 1'b1;
                  cnt_in               = cnt_ff + 2'd1;
               end else if (head_data.end_run) begin
                  emit_need             = 1'b1;
                  emit_item.out_byte    = res_byte;
                  emit_item.byte_valid  = 1'b1;
                  emit_item.run_last    = 1'b1;
                  emit_item.packet_last = head_data.end_pkt;
                  pop_i                 = 1'b1;
                  cnt_in                = 2'd0;
               end else begin
                  pend_set = 1'b1;
                  pop_i    = 1'b1;
                  cnt_in   = 2'd0;
               end
            end
            default: begin
               if (pend_valid_ff && head_data.end_run) begin
                  emit_need             = 1'b1;
                  emit_item.out_byte    = pend_byte_ff;
                  emit_item.byte_valid  = 1'b1;
                  emit_item.run_last    = 1'b1;
                  emit_item.packet_last = head_data.end_pkt;
                  pend_clr              = 1'b1;
               end else if (head_data.end_pkt) begin
                  // empty end-of-packet marker
                  emit_need             = 1'b1;
                  emit_item.out_byte    = START_CODE_ZERO;
                  emit_item.byte_valid  = 1'b0;
                  emit_item.run_last    = 1'b1;
                  emit_item.packet_last = 1'b1;
               end
               pop_i = 1'b1;
            end
         endcase
      end
      fire = ~q_empty & (~emit_need | out_free);
      pop  = pop_i & fire;

      rsp_valid_in = (fire & emit_need) | (rsp_valid_ff & rsp_stall);
      pend_valid_in = pend_valid_ff;
      if (fire && pend_clr) begin
         pend_valid_in = 1'b0;
      end
      if (fire && pend_set) begin
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= 2'd0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (fire) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit_need) begin
         rsp_data_ff <= emit_item;
      end
      if (fire && pend_set) begin
         pend_byte_ff <= res_byte;
      end
   end

endmodule

FILE: sv/length_prefixed_nal_to_start_code.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_nal_to_start_code
// Length-prefixed NAL packets in, start-code delimited byte stream out.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one packet byte per beat with the packet byte count and a last
//    flag. rsp_*: one output byte per beat with byte_valid, run_last and
//    packet_last. Both use valid/stall; a beat moves when valid and !stall.
//  - csr_*: write of the length-field size (1..4 converts, anything else
//    passes packets through). Always ready; write only while idle.
//  - Path: with an idle back end, the result of a payload or pass-through
//    byte goes through the command queue and the output register to rsp_*;
//    the held head bytes are replayed after the byte that completes the head.
//  - Throughput: one byte per cycle for payload and pass-through bytes
//    while req_stall is low. Each start code expands to four output bytes
//    on the back end; the queue between front and back absorbs that. At the
//    packet head, after the first min(4, length) bytes, the front replays
//    them with req_stall high, and the replay waits while the queue is full.
//  - rsp_stall holds the output register; once the command queue fills,
//    req_stall rises. No byte is lost to back-pressure.
//  - Reset: back to head detection, size register 4, queue and output
//    empty. No clearing pass.
// ----------------------------------------------------------------------------
module length_prefixed_nal_to_start_code #(
   parameter int CMD_QUEUE_DEPTH = lpn2sc_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lpn2sc_pkg::req_item_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lpn2sc_pkg::rsp_item_type  rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_data
);
   import lpn2sc_pkg::*;

   logic [2:0] lfb_ff;
   cmd_type    cmd_push_data;
   cmd_type    cmd_head;
   logic       cmd_push;
   logic       cmd_pop;
   logic       q_full;
   logic       q_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lfb_ff <= LFB_RESET;
      end else if (csr_valid && csr_ready) begin
         lfb_ff <= csr_data;
      end
   end

   lpn2sc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg_lfb   (lfb_ff),
      .q_full    (q_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_push_data)
   );

   lpn2sc_cmdq #(
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .pop       (cmd_pop),
      .head_data (cmd_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   lpn2sc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (cmd_head),
      .q_empty   (q_empty),
      .pop       (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/lpn2sc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpn2sc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lpn2sc_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  lpn2sc_pkg::rsp_item_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // an empty beat only ever closes a packet
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |->
         rsp_data.run_last && rsp_data.packet_last && rsp_data.out_byte == 8'h00)
      else $error("malformed end marker");

   a_pkt_end_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_last |-> rsp_data.run_last)
      else $error("packet end without run end");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind length_prefixed_nal_to_start_code lpn2sc_checker u_lpn2sc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
